/* hw/rtl/puw_pkg.sv */
// Shared types, constants and register codes for the point unprojection unit.
`timescale 1ns / 1ps

package puw_pkg;

   // Samples summed into the mean intensity
   localparam int COLOR_SAMPLES = 8;

   // Field widths
   localparam int FUNC_WIDTH   = 2;
   localparam int ID_WIDTH     = 25;   // inverse depth, Q4.21
   localparam int REM_WIDTH    = 25;
   localparam int DEPTH_WIDTH  = 32;   // depth, Q16.16
   localparam int MAG_WIDTH    = 38;   // normalised magnitude, Q.24
   localparam int CAM_WIDTH    = 41;   // camera coordinate, Q.16
   localparam int PROD_WIDTH   = 61;   // rotation entry times camera coordinate
   localparam int ACC_WIDTH    = 64;
   localparam int MEAN_WIDTH   = 11;
   localparam int CSR_IDX_WIDTH = 3;

   // Reciprocal pipeline: quotient bits per stage and stage count
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = DEPTH_WIDTH / DIV_BITS;

   // Upper dividend bits left over above the quotient (2^37 >> 32)
   localparam logic [REM_WIDTH-1:0] REM_INIT = REM_WIDTH'(32);
   // Inverse depths at or below this give a depth beyond 32 bits
   localparam logic [ID_WIDTH-1:0]  SAT_ID_LIMIT = ID_WIDTH'(32);

   // Point classes
   localparam logic [FUNC_WIDTH-1:0] FUNC_IMMATURE = 2'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNDEF    = 2'd3;

   // Register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_INV_FOCAL        = 3'd0,
      REG_PRINCIPAL_OFFSET = 3'd1,
      REG_ROT_ROW0         = 3'd2,
      REG_ROT_ROW1         = 3'd3,
      REG_ROT_ROW2         = 3'd4,
      REG_TRANSLATION      = 3'd5,
      REG_MAX_RANGE_LIMIT  = 3'd6
   } csr_index_type;

   // Reset values
   localparam logic [59:0] ROT_ROW0_RESET = 60'h400_0000_0000_0000;
   localparam logic [59:0] ROT_ROW1_RESET = 60'h000_0040_0000_0000;
   localparam logic [59:0] ROT_ROW2_RESET = 60'h000_0000_0004_0000;
   localparam logic [31:0] MAX_RANGE_RESET = 32'hFFFF_FFFF;

   // Per-point data carried alongside the reciprocal pipeline
   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic                  keep;
      logic                  neg_x;
      logic                  neg_y;
      logic [MAG_WIDTH-1:0]  mag_x;
      logic [MAG_WIDTH-1:0]  mag_y;
      logic [MEAN_WIDTH-1:0] mean;
   } side_type;

endpackage

/* hw/rtl/puw_channels.sv */
// Handshake channel interfaces for points, results and register writes.
`timescale 1ns / 1ps

interface puw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] pixel_u;
   logic [15:0] pixel_v;
   logic [23:0] idepth_first;
   logic [23:0] idepth_second;
   logic [63:0] color_samples;
   modport source (output valid, func, pixel_u, pixel_v, idepth_first, idepth_second,
                   color_samples, input ready);
   modport sink   (input valid, func, pixel_u, pixel_v, idepth_first, idepth_second,
                   color_samples, output ready);
endinterface

interface puw_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic signed [31:0] world_z;
   logic [10:0]        mean_intensity;
   logic [1:0]         point_class;
   modport source (output valid, world_x, world_y, world_z, mean_intensity, point_class,
                   input ready);
   modport sink   (input valid, world_x, world_y, world_z, mean_intensity, point_class,
                   output ready);
endinterface

interface puw_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/puw_recip.sv */
// Pipelined restoring divider giving depth = 2^37 / inverse depth, saturating.
`timescale 1ns / 1ps

module puw_recip (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [puw_pkg::ID_WIDTH-1:0]         in_id,
   input  puw_pkg::side_type                    in_side,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [puw_pkg::DEPTH_WIDTH-1:0]      out_depth,
   output puw_pkg::side_type                    out_side
);

   localparam int N = puw_pkg::DIV_STAGES;

   logic                                v_ff    [N];
   logic                                sat_ff  [N];
   logic [puw_pkg::REM_WIDTH-1:0]       r_ff    [N];
   logic [puw_pkg::REM_WIDTH-1:0]       r_in    [N];
   logic [puw_pkg::DEPTH_WIDTH-1:0]     q_ff    [N];
   logic [puw_pkg::DEPTH_WIDTH-1:0]     q_in    [N];
   logic [puw_pkg::ID_WIDTH-1:0]        id_ff   [N];
   puw_pkg::side_type                   side_ff [N];

   logic                                src_v    [N];
   logic                                src_sat  [N];
   logic [puw_pkg::REM_WIDTH-1:0]       src_r    [N];
   logic [puw_pkg::DEPTH_WIDTH-1:0]     src_q    [N];
   logic [puw_pkg::ID_WIDTH-1:0]        src_id   [N];
   puw_pkg::side_type                   src_side [N];
   logic                                en       [N+1];

   assign en[N]    = out_ready;
   assign in_ready = en[0];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         // Pick the stage source: the port for the first stage, else the stage before
         if (i == 0) begin : g_head
            assign src_v[i]    = in_valid;
            assign src_sat[i]  = (in_id <= puw_pkg::SAT_ID_LIMIT);
            assign src_r[i]    = puw_pkg::REM_INIT;
            assign src_q[i]    = '0;
            assign src_id[i]   = in_id;
            assign src_side[i] = in_side;
         end else begin : g_body
            assign src_v[i]    = v_ff[i-1];
            assign src_sat[i]  = sat_ff[i-1];
            assign src_r[i]    = r_ff[i-1];
            assign src_q[i]    = q_ff[i-1];
            assign src_id[i]   = id_ff[i-1];
            assign src_side[i] = side_ff[i-1];
         end

         // Advance when empty or when the next stage moves
         assign en[i] = ~v_ff[i] | en[i+1];

         // Resolve a few quotient bits
         always_comb begin : step
            logic [puw_pkg::REM_WIDTH:0]     r2;
            logic [puw_pkg::REM_WIDTH:0]     diff;
            logic [puw_pkg::REM_WIDTH-1:0]   r;
            logic [puw_pkg::DEPTH_WIDTH-1:0] q;
            r = src_r[i];
            q = src_q[i];
            for (int j = 0; j < puw_pkg::DIV_BITS; j++) begin
               r2   = {r, 1'b0};
               diff = r2 - {1'b0, src_id[i]};
               if (r2 >= {1'b0, src_id[i]}) begin
                  r = diff[puw_pkg::REM_WIDTH-1:0];
                  q = {q[puw_pkg::DEPTH_WIDTH-2:0], 1'b1};
               end else begin
                  r = r2[puw_pkg::REM_WIDTH-1:0];
                  q = {q[puw_pkg::DEPTH_WIDTH-2:0], 1'b0};
               end
            end
            r_in[i] = r;
            q_in[i] = q;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (en[i]) begin
               v_ff[i] <= src_v[i];
            end
         end

         always_ff @(posedge clock) begin
            if (en[i]) begin
               sat_ff[i]  <= src_sat[i];
               r_ff[i]    <= r_in[i];
               q_ff[i]    <= q_in[i];
               id_ff[i]   <= src_id[i];
               side_ff[i] <= src_side[i];
            end
         end
      end
   endgenerate

   // Saturate small inverse depths
   assign out_valid = v_ff[N-1];
   assign out_depth = sat_ff[N-1] ? '1 : q_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

/* hw/rtl/point_unproject_to_world_unit.sv */
// Top level: back-projects image points through intrinsics, depth and a rigid transform.
//
//  channel  dir  carries
//  req_if   in   func, pixel_u, pixel_v, idepth_first, idepth_second, color_samples
//  rsp_if   out  world_x, world_y, world_z, mean_intensity, point_class
//  csr_if   in   register index and 64-bit data, always ready
//
// One point enters per cycle unless the output stalls; the pipeline runs S1, S2, the
// DIV_STAGES reciprocal stages, which resolve four quotient bits each, then M1, M2, W1, W2.
// Every stage holds its own valid bit and moves when empty or when the stage after
// it moves, so bubbles close up and a stalled output holds without loss.
// Synchronous reset clears valid bits and restores the register defaults.
// Dropped points (class 3, or out of range when not immature) are removed at the output stage.
`timescale 1ns / 1ps

module point_unproject_to_world_unit (
   input logic        clock,
   input logic        reset,
   puw_req_if.sink    req_if,
   puw_rsp_if.source  rsp_if,
   puw_csr_if.sink    csr_if
);

   // Configuration registers
   logic [63:0] inv_focal_ff;
   logic [63:0] principal_offset_ff;
   logic [59:0] rot_ff [3];
   logic [62:0] translation_ff;
   logic [31:0] max_range_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_ff        <= '0;
         principal_offset_ff <= '0;
         rot_ff[0]           <= puw_pkg::ROT_ROW0_RESET;
         rot_ff[1]           <= puw_pkg::ROT_ROW1_RESET;
         rot_ff[2]           <= puw_pkg::ROT_ROW2_RESET;
         translation_ff      <= '0;
         max_range_ff        <= puw_pkg::MAX_RANGE_RESET;
      end else if (csr_if.valid) begin
         case (puw_pkg::csr_index_type'(csr_if.index))
            puw_pkg::REG_INV_FOCAL:        inv_focal_ff        <= csr_if.data;
            puw_pkg::REG_PRINCIPAL_OFFSET: principal_offset_ff <= csr_if.data;
            puw_pkg::REG_ROT_ROW0:         rot_ff[0]           <= csr_if.data[59:0];
            puw_pkg::REG_ROT_ROW1:         rot_ff[1]           <= csr_if.data[59:0];
            puw_pkg::REG_ROT_ROW2:         rot_ff[2]           <= csr_if.data[59:0];
            puw_pkg::REG_TRANSLATION:      translation_ff      <= csr_if.data[62:0];
            puw_pkg::REG_MAX_RANGE_LIMIT:  max_range_ff        <= csr_if.data[31:0];
            default: ;
         endcase
      end
   end

   // Stage enables, last to first
   logic en_w2, en_w1, en_m2, en_m1, en_s2, en_s1;
   logic div_in_ready;

   // ---------------- Stage S1: inverse depth, mean, intrinsic products
   logic                                 s1_v_ff;
   logic [1:0]                           s1_func_ff;
   logic [puw_pkg::ID_WIDTH-1:0]         s1_id_ff, s1_id_in;
   logic [47:0]                          s1_px_ff, s1_py_ff;
   logic [puw_pkg::MEAN_WIDTH-1:0]       s1_mean_ff, s1_mean_in;

   assign en_s1        = ~s1_v_ff | en_s2;
   assign req_if.ready = en_s1;

   always_comb begin : s1_calc
      logic [10:0] sum;
      logic [13:0] sum8;
      sum = '0;
      for (int k = 0; k < puw_pkg::COLOR_SAMPLES; k++) begin
         sum = sum + 11'(req_if.color_samples[8*k +: 8]);
      end
      sum8       = {sum, 3'b000};
      s1_mean_in = puw_pkg::MEAN_WIDTH'(sum8 / 14'(puw_pkg::COLOR_SAMPLES));
      if (req_if.func == puw_pkg::FUNC_IMMATURE) begin
         s1_id_in = {1'b0, req_if.idepth_first} + {1'b0, req_if.idepth_second};
      end else begin
         s1_id_in = {req_if.idepth_first, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en_s1) begin
         s1_v_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_func_ff <= req_if.func;
         s1_id_ff   <= s1_id_in;
         s1_mean_ff <= s1_mean_in;
         s1_px_ff   <= 48'(req_if.pixel_u) * 48'(inv_focal_ff[63:32]);
         s1_py_ff   <= 48'(req_if.pixel_v) * 48'(inv_focal_ff[31:0]);
      end
   end

   // ---------------- Stage S2: add principal offset, floor to Q.24, split sign
   logic                    s2_v_ff;
   logic [puw_pkg::ID_WIDTH-1:0] s2_id_ff;
   puw_pkg::side_type       s2_side_ff, s2_side_in;

   assign en_s2 = ~s2_v_ff | div_in_ready;

   always_comb begin : s2_calc
      logic signed [49:0] nx, ny;
      logic signed [37:0] n_x, n_y;
      nx = $signed({2'b00, s1_px_ff})
         + ($signed({{18{principal_offset_ff[63]}}, principal_offset_ff[63:32]}) <<< 12);
      ny = $signed({2'b00, s1_py_ff})
         + ($signed({{18{principal_offset_ff[31]}}, principal_offset_ff[31:0]}) <<< 12);
      n_x = nx[49:12];
      n_y = ny[49:12];
      s2_side_in.func  = s1_func_ff;
      s2_side_in.keep  = (s1_func_ff != puw_pkg::FUNC_UNDEF);
      s2_side_in.neg_x = n_x[37];
      s2_side_in.neg_y = n_y[37];
      s2_side_in.mag_x = n_x[37] ? 38'(-n_x) : 38'(n_x);
      s2_side_in.mag_y = n_y[37] ? 38'(-n_y) : 38'(n_y);
      s2_side_in.mean  = s1_mean_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en_s2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s2) begin
         s2_id_ff   <= s1_id_ff;
         s2_side_ff <= s2_side_in;
      end
   end

   // ---------------- Reciprocal
   logic                                div_v;
   logic [puw_pkg::DEPTH_WIDTH-1:0]     div_d;
   puw_pkg::side_type                   div_side;

   puw_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_ready  (div_in_ready),
      .in_id     (s2_id_ff),
      .in_side   (s2_side_ff),
      .out_valid (div_v),
      .out_ready (en_m1),
      .out_depth (div_d),
      .out_side  (div_side)
   );

   // ---------------- Stage M1: range test, partial products with depth
   logic        m1_v_ff, m1_keep_ff, m1_keep_in;
   logic [1:0]  m1_func_ff;
   logic        m1_neg_x_ff, m1_neg_y_ff;
   logic [puw_pkg::MEAN_WIDTH-1:0]   m1_mean_ff;
   logic [puw_pkg::DEPTH_WIDTH-1:0]  m1_d_ff;
   logic [53:0] m1_ax_ff, m1_ay_ff;
   logic [47:0] m1_bx_ff, m1_by_ff;

   assign en_m1 = ~m1_v_ff | en_m2;
   assign m1_keep_in = div_side.keep
                     & ~((div_side.func != puw_pkg::FUNC_IMMATURE) & (div_d > max_range_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (en_m1) begin
         m1_v_ff <= div_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en_m1) begin
         m1_keep_ff  <= m1_keep_in;
         m1_func_ff  <= div_side.func;
         m1_neg_x_ff <= div_side.neg_x;
         m1_neg_y_ff <= div_side.neg_y;
         m1_mean_ff  <= div_side.mean;
         m1_d_ff     <= div_d;
         m1_ax_ff    <= 54'(div_side.mag_x[37:16]) * 54'(div_d);
         m1_ay_ff    <= 54'(div_side.mag_y[37:16]) * 54'(div_d);
         m1_bx_ff    <= 48'(div_side.mag_x[15:0]) * 48'(div_d);
         m1_by_ff    <= 48'(div_side.mag_y[15:0]) * 48'(div_d);
      end
   end

   // ---------------- Stage M2: camera coordinates, clamped
   logic        m2_v_ff, m2_keep_ff;
   logic [1:0]  m2_func_ff;
   logic [puw_pkg::MEAN_WIDTH-1:0]         m2_mean_ff;
   logic signed [puw_pkg::CAM_WIDTH-1:0]   m2_cam_ff [3];
   logic signed [puw_pkg::CAM_WIDTH-1:0]   m2_cam_in [3];

   assign en_m2 = ~m2_v_ff | en_w1;

   function automatic logic signed [puw_pkg::CAM_WIDTH-1:0] cam_value(
      input logic [53:0] a, input logic [47:0] b, input logic neg);
      logic [54:0] s;
      logic [46:0] r;
      logic [40:0] lim;
      s   = 55'(a) + 55'(b[47:16]);
      r   = s[54:8];
      lim = 41'h100_0000_0000;
      if (neg) begin
         cam_value = (r >= 47'(lim)) ? $signed(lim) : $signed(-r[40:0]);
      end else begin
         cam_value = (r >= 47'(lim)) ? $signed(lim - 41'd1) : $signed(r[40:0]);
      end
   endfunction

   assign m2_cam_in[0] = cam_value(m1_ax_ff, m1_bx_ff, m1_neg_x_ff);
   assign m2_cam_in[1] = cam_value(m1_ay_ff, m1_by_ff, m1_neg_y_ff);
   assign m2_cam_in[2] = $signed({9'b0, m1_d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_v_ff <= 1'b0;
      end else if (en_m2) begin
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_m2) begin
         m2_keep_ff <= m1_keep_ff;
         m2_func_ff <= m1_func_ff;
         m2_mean_ff <= m1_mean_ff;
         for (int c = 0; c < 3; c++) begin
            m2_cam_ff[c] <= m2_cam_in[c];
         end
      end
   end

   // ---------------- Stage W1: rotation products
   logic        w1_v_ff, w1_keep_ff;
   logic [1:0]  w1_func_ff;
   logic [puw_pkg::MEAN_WIDTH-1:0]          w1_mean_ff;
   logic signed [puw_pkg::PROD_WIDTH-1:0]   w1_p_ff [3][3];

   assign en_w1 = ~w1_v_ff | en_w2;

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_v_ff <= 1'b0;
      end else if (en_w1) begin
         w1_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_w1) begin
         w1_keep_ff <= m2_keep_ff;
         w1_func_ff <= m2_func_ff;
         w1_mean_ff <= m2_mean_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               w1_p_ff[r][c] <= puw_pkg::PROD_WIDTH'($signed(rot_ff[r][59-20*c -: 20]))
                              * puw_pkg::PROD_WIDTH'(m2_cam_ff[c]);
            end
         end
      end
   end

   // ---------------- Stage W2: sum, translate, floor to Q.16, saturate (output word)
   logic        w2_v_ff;
   logic [1:0]  w2_func_ff;
   logic [puw_pkg::MEAN_WIDTH-1:0] w2_mean_ff;
   logic signed [31:0] w2_world_ff [3];
   logic signed [31:0] w2_world_in [3];

   assign en_w2 = ~w2_v_ff | rsp_if.ready;

   always_comb begin : w2_calc
      logic signed [puw_pkg::ACC_WIDTH-1:0] acc;
      logic signed [puw_pkg::ACC_WIDTH-1:0] q;
      logic signed [20:0]                   t;
      for (int r = 0; r < 3; r++) begin
         t   = $signed(translation_ff[62-21*r -: 21]);
         acc = puw_pkg::ACC_WIDTH'(w1_p_ff[r][0]) + puw_pkg::ACC_WIDTH'(w1_p_ff[r][1])
             + puw_pkg::ACC_WIDTH'(w1_p_ff[r][2]) + (puw_pkg::ACC_WIDTH'(t) <<< 25);
         q   = acc >>> 18;
         if (q > 64'sd2147483647) begin
            w2_world_in[r] = 32'sh7FFF_FFFF;
         end else if (q < -64'sd2147483648) begin
            w2_world_in[r] = 32'sh8000_0000;
         end else begin
            w2_world_in[r] = q[31:0];
         end
      end
   end

   // Drop points flagged for removal here
   always_ff @(posedge clock) begin
      if (reset) begin
         w2_v_ff <= 1'b0;
      end else if (en_w2) begin
         w2_v_ff <= w1_v_ff & w1_keep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_w2) begin
         w2_func_ff <= w1_func_ff;
         w2_mean_ff <= w1_mean_ff;
         for (int r = 0; r < 3; r++) begin
            w2_world_ff[r] <= w2_world_in[r];
         end
      end
   end

   assign rsp_if.valid          = w2_v_ff;
   assign rsp_if.world_x        = w2_world_ff[0];
   assign rsp_if.world_y        = w2_world_ff[1];
   assign rsp_if.world_z        = w2_world_ff[2];
   assign rsp_if.mean_intensity = w2_mean_ff;
   assign rsp_if.point_class    = w2_func_ff;

endmodule
